### sv/twec_pkg.sv
// ----------------------------------------------------------------------------
// twec_pkg: shared types and constants of the time window event clusterer
// Holds field widths, register indexes and the cluster record that travels
// from the front end through the queue to the output stage.
// ----------------------------------------------------------------------------
package twec_pkg;

  localparam int INDEX_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 2;

  localparam int STAMP_W   = 32;
  localparam int DUR_W     = 24;
  localparam int INDEX_W   = 24;
  localparam int COUNT_W   = 25;
  localparam int END_W     = 33;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_END   = 2'd1,
    CFG_GROUP_SPAN   = 2'd2
  } cfg_reg_t;

  // Snapshot of one cluster; the length is formed from it in the output stage.
  typedef struct packed {
    logic [INDEX_W-1:0] first_index;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] start;
    logic [END_W-1:0]   latest_end;
  } cluster_rec_t;

  // Results caused by one item: the cluster it closed, then the one it flushed.
  typedef struct packed {
    logic         closed_vld;
    logic         flushed_vld;
    cluster_rec_t closed;
    cluster_rec_t flushed;
  } q_entry_t;

  typedef struct packed {
    logic [STAMP_W-1:0] window_start;
    logic [STAMP_W-1:0] window_end;
    logic [STAMP_W-1:0] group_span;
  } cfg_regs_t;

endpackage

### sv/twec_front.sv
// ----------------------------------------------------------------------------
// twec_front: event classifier and open cluster tracker
// Tests each item against the window and the join limit, updates the open
// cluster and hands the clusters an item reports to the queue.
// ----------------------------------------------------------------------------
module twec_front #(
  parameter int INDEX_BITS = twec_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  twec_pkg::cfg_regs_t              cfg,
  input  logic                             accept,
  input  logic [twec_pkg::STAMP_W-1:0]     stamp,
  input  logic [twec_pkg::DUR_W-1:0]       span_ms,
  input  logic                             last_entry,
  output logic                             push,
  output twec_pkg::q_entry_t               push_entry
);

  logic                           open_r, open_nxt;
  logic [INDEX_BITS-1:0]          position_r, position_nxt;
  logic [twec_pkg::STAMP_W-1:0]   start_r, start_nxt;
  logic [twec_pkg::INDEX_W-1:0]   index_r, index_nxt;
  logic [twec_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [twec_pkg::END_W-1:0]     latest_r, latest_nxt;

  logic [twec_pkg::STAMP_W-1:0]   span_eff;
  logic [twec_pkg::END_W-1:0]     join_limit;
  logic [twec_pkg::END_W-1:0]     ev_end;
  logic [31:0]                    pos_ext;
  logic                           in_window;
  logic                           joins;
  logic                           closes;
  logic                           flushes;

  assign span_eff   = (cfg.group_span == '0) ? twec_pkg::STAMP_W'(1) : cfg.group_span;
  assign join_limit = {1'b0, start_r} + {1'b0, span_eff};
  assign ev_end     = {1'b0, stamp} + twec_pkg::END_W'(span_ms);
  assign pos_ext    = 32'(position_r);
  assign in_window  = (stamp >= cfg.window_start) && (stamp < cfg.window_end);
  assign joins      = open_r && ({1'b0, stamp} < join_limit);
  assign closes     = in_window && open_r && !joins;

  always_comb begin
    open_nxt     = open_r;
    start_nxt    = start_r;
    index_nxt    = index_r;
    count_nxt    = count_r;
    latest_nxt   = latest_r;
    position_nxt = position_r;
    flushes      = 1'b0;
    if (accept) begin
      if (in_window) begin
        if (joins) begin
          if (count_r != twec_pkg::COUNT_MAX) begin
            count_nxt = count_r + twec_pkg::COUNT_W'(1);
          end
          if (ev_end > latest_r) begin
            latest_nxt = ev_end;
          end
        end else begin
          open_nxt   = 1'b1;
          start_nxt  = stamp;
          index_nxt  = pos_ext[twec_pkg::INDEX_W-1:0];
          count_nxt  = twec_pkg::COUNT_W'(1);
          latest_nxt = ev_end;
        end
      end
      if (last_entry) begin
        flushes      = open_nxt;
        open_nxt     = 1'b0;
        position_nxt = '0;
      end else begin
        position_nxt = position_r + {{(INDEX_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  always_comb begin
    push_entry.closed_vld             = closes;
    push_entry.flushed_vld            = flushes;
    push_entry.closed.first_index     = index_r;
    push_entry.closed.count           = count_r;
    push_entry.closed.start           = start_r;
    push_entry.closed.latest_end      = latest_r;
    push_entry.flushed.first_index    = index_nxt;
    push_entry.flushed.count          = count_nxt;
    push_entry.flushed.start          = start_nxt;
    push_entry.flushed.latest_end     = latest_nxt;
  end

  assign push = accept && (closes || flushes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      position_r <= '0;
    end else begin
      open_r     <= open_nxt;
      position_r <= position_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    index_r  <= index_nxt;
    count_r  <= count_nxt;
    latest_r <= latest_nxt;
  end

endmodule

### sv/twec_queue.sv
// ----------------------------------------------------------------------------
// twec_queue: short queue of pending result entries
// Separates the front end from the output stage so that each can stall on
// its own; holds one entry per item that reports at least one cluster.
// ----------------------------------------------------------------------------
module twec_queue #(
  parameter int DEPTH = twec_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  twec_pkg::q_entry_t push_entry,
  input  logic               pop,
  output twec_pkg::q_entry_t head,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  twec_pkg::q_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign head  = entries_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### sv/twec_back.sv
// ----------------------------------------------------------------------------
// twec_back: result output stage
// Unpacks each queue entry into one or two result items, forms the cluster
// length and holds the item in the output register until it is taken.
// ----------------------------------------------------------------------------
module twec_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  twec_pkg::q_entry_t             head,
  input  logic                           empty,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [twec_pkg::INDEX_W-1:0]   out_first_index,
  output logic [twec_pkg::COUNT_W-1:0]   out_member_count,
  output logic [twec_pkg::STAMP_W-1:0]   out_cluster_start,
  output logic [twec_pkg::END_W-1:0]     out_cluster_length,
  output logic                           out_last_of_run
);

  logic                         valid_r, valid_nxt;
  logic                         second_r, second_nxt;
  logic                         load;
  logic                         use_closed;
  twec_pkg::cluster_rec_t       rec;
  logic [twec_pkg::INDEX_W-1:0] index_r;
  logic [twec_pkg::COUNT_W-1:0] count_r;
  logic [twec_pkg::STAMP_W-1:0] start_r;
  logic [twec_pkg::END_W-1:0]   length_r;
  logic                         last_r;

  // The output register may take a new item when it is empty or being taken.
  assign load       = (!valid_r || !out_stall) && !empty;
  assign use_closed = head.closed_vld && !second_r;
  assign rec        = use_closed ? head.closed : head.flushed;

  always_comb begin
    valid_nxt  = valid_r;
    second_nxt = second_r;
    pop        = 1'b0;
    if (!valid_r || !out_stall) begin
      valid_nxt = !empty;
    end
    if (load) begin
      if (use_closed && head.flushed_vld) begin
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      index_r  <= rec.first_index;
      count_r  <= rec.count;
      start_r  <= rec.start;
      length_r <= rec.latest_end - {1'b0, rec.start};
      last_r   <= !(use_closed && head.flushed_vld);
    end
  end

  assign out_valid          = valid_r;
  assign out_first_index    = index_r;
  assign out_member_count   = count_r;
  assign out_cluster_start  = start_r;
  assign out_cluster_length = length_r;
  assign out_last_of_run    = last_r;

endmodule

### sv/time_window_event_clusterer_core.sv
// ----------------------------------------------------------------------------
// time_window_event_clusterer_core: greedy fixed span event clustering
// Groups timed events inside a configurable window into clusters and
// reports first index, member count, start time and length of each.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the in_ channel (in_valid / in_stall) in nondecreasing
//   stamp order. An item is taken at each edge where in_valid is high and
//   in_stall is low. Cluster reports leave on the out_ channel under the same
//   rule; out_last_of_run marks the final report caused by one input item.
//   The cfg_ channel writes window_start (0), window_end (1) and group_span
//   (2) with a valid/ready handshake; cfg_ready is always high and writes to
//   index 3 are dropped. Registers are meant to change only while idle.
//   Throughput is one item per cycle while in_stall is low. The first report
//   of an item is written into the queue and then loaded into the output
//   register. An item that closes one cluster and flushes another produces
//   two reports, one after the other, so the output register and its
//   one-port drain set the sustained rate in that case.
//   A receiver stall freezes the output register; the two-entry queue behind
//   it fills, and in_stall rises only when that queue is full.
//   Reset (rst_n low, synchronous) closes any open cluster, restarts the
//   stream position at zero, empties the queue and restores register
//   defaults (window 0 to 0xFFFFFFFF, group span 1).
// ----------------------------------------------------------------------------
module time_window_event_clusterer_core #(
  parameter int INDEX_BITS = twec_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // event input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [twec_pkg::STAMP_W-1:0]     in_stamp,
  input  logic [twec_pkg::DUR_W-1:0]       in_span_ms,
  input  logic                             in_last_entry,
  // cluster reports
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [twec_pkg::INDEX_W-1:0]     out_first_index,
  output logic [twec_pkg::COUNT_W-1:0]     out_member_count,
  output logic [twec_pkg::STAMP_W-1:0]     out_cluster_start,
  output logic [twec_pkg::END_W-1:0]       out_cluster_length,
  output logic                             out_last_of_run,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [twec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twec_pkg::STAMP_W-1:0]     cfg_wdata
);

  twec_pkg::cfg_regs_t cfg_r, cfg_nxt;
  twec_pkg::q_entry_t  push_entry;
  twec_pkg::q_entry_t  head;
  logic                accept;
  logic                push;
  logic                pop;
  logic                q_empty;
  logic                q_full;

  // Configuration registers. Writes are always taken; an unused index is
  // simply ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (twec_pkg::cfg_reg_t'(cfg_index))
        twec_pkg::CFG_WINDOW_START: cfg_nxt.window_start = cfg_wdata;
        twec_pkg::CFG_WINDOW_END:   cfg_nxt.window_end   = cfg_wdata;
        twec_pkg::CFG_GROUP_SPAN:   cfg_nxt.group_span   = cfg_wdata;
        default:                    cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start <= '0;
      cfg_r.window_end   <= '1;
      cfg_r.group_span   <= twec_pkg::STAMP_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The input side backs up only when the queue has no room for another
  // entry, so a full output register alone never stops the front end.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  twec_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .stamp      (in_stamp),
    .span_ms    (in_span_ms),
    .last_entry (in_last_entry),
    .push       (push),
    .push_entry (push_entry)
  );

  twec_queue #(
    .DEPTH (twec_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  twec_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .empty              (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_first_index    (out_first_index),
    .out_member_count   (out_member_count),
    .out_cluster_start  (out_cluster_start),
    .out_cluster_length (out_cluster_length),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
